// ===== src/assert_macros.svh =====
// Assertion shorthands, clocked on i_clk and disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every rising clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/teq_pkg.sv =====
package teq_pkg;

    // defaults for the top-level parameters
    localparam int QUEUE_DEPTH_DFLT = 64;
    localparam int ID_BITS_DFLT     = 16;

    // opcodes
    localparam logic [1:0] OP_SCHEDULE   = 2'd0;
    localparam logic [1:0] OP_DESCHEDULE = 2'd1;
    localparam logic [1:0] OP_POP        = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_EMPTY   = 3'd1;
    localparam logic [2:0] ST_PAST    = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_BADID   = 3'd4;
    localparam logic [2:0] ST_STOPPED = 3'd5;

    // request payload
    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] event_id;
        logic [63:0] payload;
        logic [63:0] due_tick;
    } t_req;

    // response payload
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] out_event_id;
        logic [63:0] out_payload;
        logic [63:0] current_tick;
        logic [63:0] handled_count;
        logic [6:0]  entries_used;
    } t_rsp;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins_en;   // insert the new entry at its ordered place
        logic del_en;   // remove the first entry whose id matches
        logic pop_en;   // remove the head entry
    } t_cell_ctl;

endpackage

// ===== src/teq_stream_if.sv =====
interface teq_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/teq_cell.sv =====
// One slot of the ordered queue. Slot 0 is the head; a cell trades
// contents with its left (earlier) or right (later) neighbor.
module teq_cell #(
    parameter int ID_BITS = teq_pkg::ID_BITS_DFLT
) (
    input  logic                 i_clk,
    input  teq_pkg::t_cell_ctl   i_ctl,
    input  logic                 i_valid,
    input  logic [ID_BITS-1:0]   i_new_id,
    input  logic [63:0]          i_new_payload,
    input  logic [63:0]          i_new_tick,
    input  logic [ID_BITS-1:0]   i_left_id,
    input  logic [63:0]          i_left_payload,
    input  logic [63:0]          i_left_tick,
    input  logic                 i_left_ins,
    input  logic                 i_left_hit,
    input  logic [ID_BITS-1:0]   i_right_id,
    input  logic [63:0]          i_right_payload,
    input  logic [63:0]          i_right_tick,
    output logic [ID_BITS-1:0]   o_id,
    output logic [63:0]          o_payload,
    output logic [63:0]          o_tick,
    output logic                 o_ins,
    output logic                 o_hit
);

    logic [ID_BITS-1:0] r_id;
    logic [63:0]        r_payload;
    logic [63:0]        r_tick;
    logic [ID_BITS-1:0] n_id;
    logic [63:0]        n_payload;
    logic [63:0]        n_tick;

    // new entry belongs here or earlier: slot is free or due later
    assign o_ins = !i_valid || (r_tick > i_new_tick);
    // first id match is at or before this slot
    assign o_hit = i_left_hit || (i_valid && (r_id == i_new_id));

    assign o_id      = r_id;
    assign o_payload = r_payload;
    assign o_tick    = r_tick;

    // next contents: keep, shift right, take new, or shift left
    always_comb begin
        n_id      = r_id;
        n_payload = r_payload;
        n_tick    = r_tick;
        if (i_ctl.ins_en) begin
            if (i_left_ins) begin
                n_id      = i_left_id;
                n_payload = i_left_payload;
                n_tick    = i_left_tick;
            end else if (o_ins) begin
                n_id      = i_new_id;
                n_payload = i_new_payload;
                n_tick    = i_new_tick;
            end
        end else if (i_ctl.pop_en || (i_ctl.del_en && o_hit)) begin
            n_id      = i_right_id;
            n_payload = i_right_payload;
            n_tick    = i_right_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id      <= n_id;
        r_payload <= n_payload;
        r_tick    <= n_tick;
    end

endmodule

// ===== src/timed_event_queue.sv =====
// Time-ordered event queue: a row of QUEUE_DEPTH cells kept sorted by due
// tick (equal ticks first in, first out). A request is registered in idle;
// the execute state compares it against every cell at once and shifts the
// row, waiting while the output register holds an untaken response. A new
// request is taken only in idle, while the previous response may still sit
// in the output register. The execute path is set by the tick compare in
// each cell and the deschedule first-match chain along the row. Halt is
// written through i_cfg_we/i_cfg_wdata and only affects pop. No clearing
// pass after reset; slots at or beyond the entry count are never read.
`include "assert_macros.svh"

module timed_event_queue #(
    parameter int QUEUE_DEPTH = teq_pkg::QUEUE_DEPTH_DFLT,
    parameter int ID_BITS     = teq_pkg::ID_BITS_DFLT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    teq_stream_if.sink   i_req,
    teq_stream_if.source o_rsp
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state             r_state;
    teq_pkg::t_req      r_req;
    teq_pkg::t_rsp      r_rsp;
    logic               r_rsp_valid;
    logic               r_halt;
    logic [CW-1:0]      r_count;
    logic [63:0]        r_sim_tick;
    logic [63:0]        r_handled;

    logic [CW-1:0]      n_count;
    logic [63:0]        n_sim_tick;
    logic [63:0]        n_handled;

    logic               w_fire;
    logic [ID_BITS-1:0] w_id;
    logic [2:0]         w_status;
    teq_pkg::t_cell_ctl w_op;
    teq_pkg::t_cell_ctl w_ctl;

    logic [ID_BITS-1:0] w_cell_id      [QUEUE_DEPTH];
    logic [63:0]        w_cell_payload [QUEUE_DEPTH];
    logic [63:0]        w_cell_tick    [QUEUE_DEPTH];
    logic               w_cell_ins     [QUEUE_DEPTH];
    logic               w_cell_hit     [QUEUE_DEPTH];
    logic               w_cell_valid   [QUEUE_DEPTH];

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_rsp_valid;
    assign o_rsp.data  = r_rsp;

    // execute completes once the output register can take the response
    assign w_fire = (r_state == S_EXEC) && (!r_rsp_valid || o_rsp.ready);
    assign w_id   = ID_BITS'(r_req.event_id);

    // decode and check the held request
    always_comb begin
        w_status = teq_pkg::ST_OK;
        w_op     = '0;
        case (r_req.opcode)
            teq_pkg::OP_SCHEDULE: begin
                if (w_id == '0) begin
                    w_status = teq_pkg::ST_BADID;
                end else if (r_req.due_tick < r_sim_tick) begin
                    w_status = teq_pkg::ST_PAST;
                end else if (r_count == CW'(QUEUE_DEPTH)) begin
                    w_status = teq_pkg::ST_FULL;
                end else begin
                    w_op.ins_en = 1'b1;
                end
            end
            teq_pkg::OP_DESCHEDULE: begin
                if (w_id == '0) begin
                    w_status = teq_pkg::ST_BADID;
                end else begin
                    w_op.del_en = 1'b1;
                    if (!w_cell_hit[QUEUE_DEPTH-1]) begin
                        w_status = teq_pkg::ST_EMPTY;
                    end
                end
            end
            teq_pkg::OP_POP: begin
                if (r_halt) begin
                    w_status = teq_pkg::ST_STOPPED;
                end else if (r_count == '0) begin
                    w_status = teq_pkg::ST_EMPTY;
                end else begin
                    w_op.pop_en = 1'b1;
                end
            end
            default: begin
                w_status = teq_pkg::ST_BADID;
            end
        endcase
    end

    assign w_ctl.ins_en = w_fire && w_op.ins_en;
    assign w_ctl.del_en = w_fire && w_op.del_en;
    assign w_ctl.pop_en = w_fire && w_op.pop_en;

    // counters after this request
    always_comb begin
        n_count    = r_count;
        n_sim_tick = r_sim_tick;
        n_handled  = r_handled;
        if (w_op.ins_en) begin
            n_count = r_count + CW'(1);
        end else if (w_op.pop_en || (w_op.del_en && w_cell_hit[QUEUE_DEPTH-1])) begin
            n_count = r_count - CW'(1);
        end
        if (w_op.pop_en) begin
            n_sim_tick = w_cell_tick[0];
            n_handled  = r_handled + 64'd1;
        end
    end

    // row of cells, head at index 0
    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        localparam int L = (k == 0) ? 0 : k - 1;
        localparam int R = (k == QUEUE_DEPTH - 1) ? k : k + 1;

        assign w_cell_valid[k] = (r_count > CW'(k));

        teq_cell #(
            .ID_BITS (ID_BITS)
        ) u_cell (
            .i_clk           (i_clk),
            .i_ctl           (w_ctl),
            .i_valid         (w_cell_valid[k]),
            .i_new_id        (w_id),
            .i_new_payload   (r_req.payload),
            .i_new_tick      (r_req.due_tick),
            .i_left_id       (w_cell_id[L]),
            .i_left_payload  (w_cell_payload[L]),
            .i_left_tick     (w_cell_tick[L]),
            .i_left_ins      ((k == 0) ? 1'b0 : w_cell_ins[L]),
            .i_left_hit      ((k == 0) ? 1'b0 : w_cell_hit[L]),
            .i_right_id      (w_cell_id[R]),
            .i_right_payload (w_cell_payload[R]),
            .i_right_tick    (w_cell_tick[R]),
            .o_id            (w_cell_id[k]),
            .o_payload       (w_cell_payload[k]),
            .o_tick          (w_cell_tick[k]),
            .o_ins           (w_cell_ins[k]),
            .o_hit           (w_cell_hit[k])
        );
    end

    // control state, counters and response payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
            r_halt      <= 1'b0;
            r_count     <= '0;
            r_sim_tick  <= '0;
            r_handled   <= '0;
        end else begin
            if (i_cfg_we) begin
                r_halt <= i_cfg_wdata;
            end
            // response register: load on execute, clear once taken
            if (w_fire) begin
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_req   <= i_req.data;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_fire) begin
                        r_count                 <= n_count;
                        r_sim_tick              <= n_sim_tick;
                        r_handled               <= n_handled;
                        r_rsp.status            <= w_status;
                        r_rsp.out_event_id      <= w_op.pop_en ? 16'(w_cell_id[0]) : '0;
                        r_rsp.out_payload       <= w_op.pop_en ? w_cell_payload[0] : '0;
                        r_rsp.current_tick      <= n_sim_tick;
                        r_rsp.handled_count     <= n_handled;
                        r_rsp.entries_used      <= 7'(n_count);
                        r_state                 <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // checks
    `ASSERT_ALWAYS(a_count_bound, r_count <= CW'(QUEUE_DEPTH), "entry count above depth")
    `ASSERT_NEXT(a_count_hold, !w_fire, $stable(r_count), "entry count moved without a request")
    `ASSERT_NEXT(a_ins_count, w_ctl.ins_en, r_count == $past(r_count) + CW'(1), "insert lost count")
    `ASSERT_IMPL(a_rsp_clean, o_rsp.valid && (o_rsp.data.status != teq_pkg::ST_OK), o_rsp.data.out_event_id == '0, "id on failed response")

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam int          DEPTH       = teq_pkg::QUEUE_DEPTH_DFLT;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int          STALL_LIMIT = 2000;
    localparam int          HOLD_CYCLES = 300;

    // Golden model of the event queue plus the list of responses still owed
    class teq_scoreboard;
        typedef struct {
            logic [15:0] id;
            logic [63:0] data;
            logic [63:0] tick;
        } event_t;

        event_t        held[$];
        bit            halted;
        logic [63:0]   now_tick;
        logic [63:0]   handled;
        teq_pkg::t_rsp owed[$];
        int            errors;

        function new();
            halted   = 1'b0;
            now_tick = '0;
            handled  = '0;
            errors   = 0;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        // Apply one accepted request and queue the response it must produce
        function void note_request(teq_pkg::t_req r);
            teq_pkg::t_rsp e;
            event_t        ev;
            int            pos;
            int            k;
            e = '0;
            e.status = teq_pkg::ST_OK;
            case (r.opcode)
                teq_pkg::OP_SCHEDULE: begin
                    if (r.event_id == '0) begin
                        e.status = teq_pkg::ST_BADID;
                    end else if (r.due_tick < now_tick) begin
                        e.status = teq_pkg::ST_PAST;
                    end else if (held.size() >= DEPTH) begin
                        e.status = teq_pkg::ST_FULL;
                    end else begin
                        // goes behind every entry due no later than itself
                        pos = held.size();
                        for (k = 0; k < held.size(); k++) begin
                            if (held[k].tick > r.due_tick) begin
                                pos = k;
                                break;
                            end
                        end
                        ev.id   = r.event_id;
                        ev.data = r.payload;
                        ev.tick = r.due_tick;
                        held.insert(pos, ev);
                    end
                end
                teq_pkg::OP_DESCHEDULE: begin
                    if (r.event_id == '0) begin
                        e.status = teq_pkg::ST_BADID;
                    end else begin
                        e.status = teq_pkg::ST_EMPTY;
                        for (k = 0; k < held.size(); k++) begin
                            if (held[k].id == r.event_id) begin
                                held.delete(k);
                                e.status = teq_pkg::ST_OK;
                                break;
                            end
                        end
                    end
                end
                teq_pkg::OP_POP: begin
                    if (halted) begin
                        e.status = teq_pkg::ST_STOPPED;
                    end else if (held.size() == 0) begin
                        e.status = teq_pkg::ST_EMPTY;
                    end else begin
                        ev = held[0];
                        held.delete(0);
                        e.out_event_id = ev.id;
                        e.out_payload  = ev.data;
                        now_tick       = ev.tick;
                        handled        = handled + 64'd1;
                    end
                end
                default: begin
                    e.status = teq_pkg::ST_BADID;
                end
            endcase
            e.current_tick  = now_tick;
            e.handled_count = handled;
            e.entries_used  = 7'(held.size());
            owed.push_back(e);
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Match one accepted response against the oldest one owed
        function void check_response(teq_pkg::t_rsp got);
            teq_pkg::t_rsp e;
            if (owed.size() == 0) begin
                $display("%0t: unexpected response: expected none, actual %p", $time, got);
                errors++;
                return;
            end
            e = owed[0];
            owed.delete(0);
            compare_field("status", 64'(e.status), 64'(got.status));
            compare_field("out_event_id", 64'(e.out_event_id), 64'(got.out_event_id));
            compare_field("out_payload", e.out_payload, got.out_payload);
            compare_field("current_tick", e.current_tick, got.current_tick);
            compare_field("handled_count", e.handled_count, got.handled_count);
            compare_field("entries_used", 64'(e.entries_used), 64'(got.entries_used));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    teq_stream_if #(.T(teq_pkg::t_req)) req_if ();
    teq_stream_if #(.T(teq_pkg::t_rsp)) rsp_if ();

    teq_scoreboard sb;
    int            tx_idle_pct = 6;
    int            rx_idle_pct = 51;
    int            hold_req    = 0;
    int            hold_seen   = 0;
    int            hold_left   = 0;
    int            quiet       = 0;

    timed_event_queue i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Response side: random back-pressure, or a long hold-off when asked
    always @(negedge clk) begin
        if (hold_req != hold_seen) begin
            hold_left = HOLD_CYCLES;
            hold_seen = hold_req;
        end
        if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
        end else begin
            rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // Monitor: feed accepted requests to the model, check accepted responses
    always @(posedge clk) begin
        if (rst_n) begin
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.data);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_response(rsp_if.data);
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
        else
            quiet++;
        if (quiet >= STALL_LIMIT) begin
            $display("%0t: timeout, nothing accepted for %0d cycles", $time, quiet);
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic teq_pkg::t_req mk_req(logic [1:0] op, logic [15:0] id,
                                             logic [63:0] data, logic [63:0] due);
        teq_pkg::t_req r;
        r.opcode   = op;
        r.event_id = id;
        r.payload  = data;
        r.due_tick = due;
        return r;
    endfunction

    // Mostly a small id pool so deschedules hit, sometimes zero or any id
    function automatic logic [15:0] random_id();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 3)
            return '0;
        else if (roll < 18)
            return 16'($urandom_range(1, 65535));
        else
            return 16'($urandom_range(1, 24));
    endfunction

    // Random request, now and then the unused opcode; pop takes whatever share the others leave
    function automatic teq_pkg::t_req random_request(int sched_pct, int desched_pct);
        teq_pkg::t_req r;
        int            roll;
        int            gap;
        logic [63:0]   now;
        now        = sb.now_tick;
        r.payload  = {$urandom, $urandom};
        r.due_tick = {$urandom, $urandom};
        r.event_id = random_id();
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            r.opcode = OP_UNUSED;
        end else if (roll < 2 + sched_pct) begin
            r.opcode = teq_pkg::OP_SCHEDULE;
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                // in the past whenever the clock has moved
                gap = $urandom_range(1, 21);
                r.due_tick = (now >= 64'(gap)) ? now - 64'(gap) : '0;
            end else if (roll >= 8) begin
                // close to the current tick, saturating at the top
                gap = $urandom_range(0, 40);
                r.due_tick = (now > ~64'd0 - 64'(gap)) ? ~64'd0 : now + 64'(gap);
            end
        end else if (roll < 2 + sched_pct + desched_pct) begin
            r.opcode = teq_pkg::OP_DESCHEDULE;
            if (sb.held.size() > 0 && $urandom_range(0, 99) < 60)
                r.event_id = sb.held[$urandom_range(0, sb.held.size() - 1)].id;
        end else begin
            r.opcode = teq_pkg::OP_POP;
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance
    task automatic send_req(teq_pkg::t_req r);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge clk); while (!(req_if.valid && req_if.ready));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_halt(bit v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.halted = v;
    endtask

    task automatic run_phase(int count, int sched_pct, int desched_pct);
        for (int i = 0; i < count; i++)
            send_req(random_request(sched_pct, desched_pct));
    endtask

    initial begin
        sb = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        write_halt(1'b0);

        // Directed: error codes, ordering with equal ticks, halt, past ticks
        send_req(mk_req(teq_pkg::OP_POP, 16'd5, '0, '0));
        send_req(mk_req(teq_pkg::OP_DESCHEDULE, 16'd7, '0, '0));
        send_req(mk_req(teq_pkg::OP_SCHEDULE, 16'd0, 64'h1, 64'd1));
        send_req(mk_req(teq_pkg::OP_DESCHEDULE, 16'd0, '0, '0));
        send_req(mk_req(OP_UNUSED, 16'd9, '1, '1));
        send_req(mk_req(teq_pkg::OP_SCHEDULE, 16'hFFFF, '1, 64'd5));
        send_req(mk_req(teq_pkg::OP_SCHEDULE, 16'd1, '0, 64'd5));
        send_req(mk_req(teq_pkg::OP_SCHEDULE, 16'h8000, 64'h5555_5555_5555_5555, 64'd0));
        send_req(mk_req(teq_pkg::OP_SCHEDULE, 16'd2, 64'hAAAA_AAAA_AAAA_AAAA, 64'd3));
        send_req(mk_req(teq_pkg::OP_DESCHEDULE, 16'd2, '0, '0));
        send_req(mk_req(teq_pkg::OP_DESCHEDULE, 16'h1234, '0, '0));
        send_req(mk_req(teq_pkg::OP_POP, '0, '0, '0));
        wait_drained();
        write_halt(1'b1);
        send_req(mk_req(teq_pkg::OP_POP, '0, '0, '0));
        send_req(mk_req(teq_pkg::OP_SCHEDULE, 16'd3, 64'h0123_4567_89AB_CDEF, 64'd9));
        wait_drained();
        write_halt(1'b0);
        send_req(mk_req(teq_pkg::OP_POP, '0, '0, '0));
        send_req(mk_req(teq_pkg::OP_SCHEDULE, 16'd4, '1, 64'd4));
        send_req(mk_req(teq_pkg::OP_SCHEDULE, 16'd0, '1, 64'd0));
        send_req(mk_req(teq_pkg::OP_POP, '0, '0, '0));
        send_req(mk_req(teq_pkg::OP_POP, '0, '0, '0));
        send_req(mk_req(teq_pkg::OP_POP, '0, '0, '0));
        wait_drained();

        // Fill toward full, with a long response hold-off at the start
        hold_req++;
        run_phase(80, 80, 5);
        // sender pauses until every response is back
        wait_drained();
        run_phase(70, 80, 5);
        wait_drained();

        // Halted: pops report stopped, the rest still works
        write_halt(1'b1);
        run_phase(50, 45, 20);
        wait_drained();
        write_halt(1'b0);

        // Drain with the idling swapped, then with no idling at all
        tx_idle_pct = 51;
        rx_idle_pct = 6;
        run_phase(130, 25, 20);
        wait_drained();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(120, 45, 20);
        wait_drained();

        repeat (8) @(posedge clk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d responses never arrived: expected 0 outstanding, actual %0d",
                     $time, sb.pending(), sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
